[design/msd_pkg.sv]
package msd_pkg;

  localparam int MaxMarks   = 5;
  localparam int MarksW     = MaxMarks;
  localparam int LenW       = $clog2(MaxMarks + 2);
  localparam int TableSize  = 36;
  localparam int RunW       = 4;
  localparam int GapW       = 4;
  localparam int CharW      = 7;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharDash  = 8'h2d;
  localparam logic [RunW-1:0] RunMax   = {RunW{1'b1}};
  localparam logic [GapW-1:0] GapMin   = GapW'(2);
  localparam logic [GapW-1:0] GapReset = GapW'(3);
  localparam logic [CharW-1:0] WordSpace = 7'h20;

  typedef struct packed {
    logic [7:0] symbol_char;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [CharW-1:0] decoded_char;
    logic             unknown_code;
  } res_t;

  typedef struct packed {
    logic             hit;
    logic [CharW-1:0] ch;
  } lookup_t;

  // code table: bit i set means mark i is a dash
  localparam logic [4:0] CodeBits [TableSize] = '{
    5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14,
    5'd5, 5'd2, 5'd3, 5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1,
    5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
    5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15, 5'd31
  };

  localparam logic [2:0] CodeLen [TableSize] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [CharW-1:0] CodeChar [TableSize] = '{
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4a,
    7'h4b, 7'h4c, 7'h4d, 7'h4e, 7'h4f, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54,
    7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5a,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
  };

  function automatic lookup_t code_lookup(input logic [MarksW-1:0] marks,
                                          input logic [LenW-1:0]   len);
    lookup_t r;
    r.hit = 1'b0;
    r.ch  = '0;
    for (int i = 0; i < TableSize; i++) begin
      if (len == LenW'(CodeLen[i]) && marks == MarksW'(CodeBits[i])) begin
        r.hit = 1'b1;
        r.ch  = CodeChar[i];
      end
    end
    return r;
  endfunction

endpackage

[design/msd_input_reg.sv]
module msd_input_reg
  import msd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  [7:0] symbol_char,
  input  logic  end_of_message,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.symbol_char    <= symbol_char;
      item.end_of_message <= end_of_message;
    end
  end

endmodule

[design/msd_decode_core.sv]
module msd_decode_core
  import msd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [GapW-1:0] cfg_wdata,
  input  logic            item_valid,
  input  item_t           item,
  input  logic            advance,
  output logic            res_valid,
  output res_t            res
);

  logic [GapW-1:0]   word_gap_spaces;
  logic [MarksW-1:0] marks, marks_next;
  logic [LenW-1:0]   len, len_next;
  logic              invalid, invalid_next;
  logic [RunW-1:0]   run, run_next;

  logic              fire;
  logic              is_space, is_dot, is_dash;
  logic [GapW-1:0]   gap;
  logic [MarksW-1:0] marks_upd;
  logic [LenW-1:0]   len_upd;
  logic              invalid_upd;
  logic              emit_code;
  lookup_t           hit;

  assign fire    = item_valid && advance;
  assign is_space = item.symbol_char == CharSpace;
  assign is_dot   = item.symbol_char == CharDot;
  assign is_dash  = item.symbol_char == CharDash;
  assign gap      = (word_gap_spaces < GapMin) ? GapMin : word_gap_spaces;
  assign hit      = code_lookup(marks_upd, len_upd);

  always_comb begin
    marks_upd   = marks;
    len_upd     = len;
    invalid_upd = invalid;
    run_next    = run;
    emit_code   = 1'b0;
    res_valid   = 1'b0;
    res.decoded_char = '0;
    res.unknown_code = 1'b0;

    if (!is_space) begin
      run_next = '0;
      if (len < LenW'(MaxMarks)) begin
        if (is_dash) begin
          marks_upd = marks | (MarksW'(1) << len);
        end else if (!is_dot) begin
          invalid_upd = 1'b1;
        end
        len_upd = len + LenW'(1);
      end else begin
        if (!is_dot && !is_dash) begin
          invalid_upd = 1'b1;
        end
        len_upd = LenW'(MaxMarks + 1);
      end
      emit_code = item.end_of_message;
    end else begin
      if (run != RunMax) begin
        run_next = run + RunW'(1);
      end
      if (len != '0) begin
        emit_code = 1'b1;
      end else if (GapW'(run) < gap && GapW'(run_next) >= gap) begin
        res_valid = fire;
        res.decoded_char = WordSpace;
      end
    end

    if (emit_code) begin
      res_valid = fire;
      if (!invalid_upd && len_upd <= LenW'(MaxMarks) && hit.hit) begin
        res.decoded_char = hit.ch;
      end else begin
        res.unknown_code = 1'b1;
      end
    end

    marks_next   = marks_upd;
    len_next     = len_upd;
    invalid_next = invalid_upd;
    // a closed pattern or the end of a message starts over
    if (emit_code || item.end_of_message) begin
      marks_next   = '0;
      len_next     = '0;
      invalid_next = 1'b0;
    end
    if (item.end_of_message) begin
      run_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_gap_spaces <= GapReset;
    end else if (cfg_we) begin
      word_gap_spaces <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marks   <= '0;
      len     <= '0;
      invalid <= 1'b0;
      run     <= '0;
    end else if (fire) begin
      marks   <= marks_next;
      len     <= len_next;
      invalid <= invalid_next;
      run     <= run_next;
    end
  end

endmodule

[design/msd_output_reg.sv]
module msd_output_reg
  import msd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  res_t             res,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CharW-1:0] decoded_char,
  output logic             unknown_code
);

  // the result register may take a new beat when it is empty or its current one leaves
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      decoded_char <= res.decoded_char;
      unknown_code <= res.unknown_code;
    end
  end

endmodule

[design/morse_stream_decoder_unit.sv]
// path: an accepted input beat is held in the input register, matched against the code
// table and captured by the result register, which drives the outputs; out_stall can hold it
// throughput: one input beat per cycle while out_stall is low, set by the combinational
// table match between the input register and the result register
// reset (rst, synchronous): clears the pattern and space run, empties both
// registers and sets the word gap length to 3
module morse_stream_decoder_unit
  import msd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [GapW-1:0]  cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       symbol_char,
  input  logic             end_of_message,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CharW-1:0] decoded_char,
  output logic             unknown_code
);

  logic  advance;
  logic  item_valid;
  item_t item;
  logic  res_valid;
  res_t  res;

  msd_input_reg u_input (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .symbol_char    (symbol_char),
    .end_of_message (end_of_message),
    .advance        (advance),
    .item_valid     (item_valid),
    .item           (item)
  );

  msd_decode_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  msd_output_reg u_output (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res          (res),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .decoded_char (decoded_char),
    .unknown_code (unknown_code)
  );

endmodule
